// File: src/pffa_pkg.sv
// shared constants, codes and types of the page frame allocator
`default_nettype none
package pffa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 48;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int LINK_W     = FRAME_W + 1;
  localparam int CNT_W      = 13;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_FRAMES);
  localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] LAST_OFS   = ADDR_W'(MAX_FRAMES - 1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] END_OFS    = ADDR_W'(MAX_FRAMES) << PAGE_SHIFT;

  localparam logic [OP_W-1:0] OP_INIT     = 2'd0;
  localparam logic [OP_W-1:0] OP_GET      = 2'd1;
  localparam logic [OP_W-1:0] OP_GET_ZERO = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_PAGE     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ZERO     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DOUBLE_FREE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END   = 2'd3;

  typedef struct packed {
    logic              zeroed;
    logic              kernel;
    logic              in_use;
    logic [LINK_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    entry_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic go;
    logic clear;
  } walk_cmd_t;

  typedef struct packed {
    logic active;
    logic last;
    logic push;
    logic reserve;
  } walk_stat_t;

endpackage
`default_nettype wire

// File: src/page_frame_free_list_allocator_core.sv
// page frame allocator top level: config, command control and frame table
//
// channel   | direction | handshake                  | payload
// in_       | input     | start high while busy low  | opcode, for_kernel, free_address
// out_      | output    | out_valid, one cycle       | status, page_address, was_zeroed, count
// cfg_      | input     | cfg_we                     | cfg_index, cfg_wdata
//
// get, get zeroed and free read the frame table entry as they are accepted and
// write it back in the exec state, where the result word is registered.
// init walks all 4096 table entries one per cycle.
// after reset a clearing pass over all table entries runs with busy high.
// the result word cannot be stalled; a new word is accepted while it shows.
`default_nettype none
module page_frame_free_list_allocator_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [pffa_pkg::OP_W-1:0]        in_opcode,
  input  wire logic                             in_for_kernel,
  input  wire logic [pffa_pkg::ADDR_W-1:0]      in_free_address,
  output      logic                             out_valid,
  output      logic [pffa_pkg::STAT_W-1:0]      out_status,
  output      logic [pffa_pkg::ADDR_W-1:0]      out_page_address,
  output      logic                             out_page_was_zeroed,
  output      logic [pffa_pkg::CNT_W-1:0]       out_frames_in_use,
  input  wire logic                             cfg_we,
  input  wire logic [pffa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pffa_pkg::ADDR_W-1:0]      cfg_wdata
);
  import pffa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_INIT  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [ADDR_W-1:0]  base_r, kstart_r, kend_r;
  logic [CNT_W-1:0]   total_r;
  logic [CNT_W-1:0]   frames;

  logic [1:0]         state_r, state_nxt;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic               kern_r, kern_nxt;
  logic [FRAME_W-1:0] idx_r, idx_nxt;
  logic               fail_r, fail_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_page_r, out_page_nxt;
  logic               out_zeroed_r, out_zeroed_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               accept;
  logic               addr_ok;
  logic [ADDR_W-1:0]  ofs;
  logic [PFN_W-1:0]   pfn;
  logic               pfn_ok;
  logic [FRAME_W-1:0] rd_addr;
  entry_t             rd_data;
  mem_wr_t            exec_wr, walk_wr, mem_wr;
  walk_cmd_t          walk_cmd;
  walk_stat_t         walk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      total_r  <= MAX_CNT;
      kstart_r <= '0;
      kend_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEMORY_BASE:  base_r   <= cfg_wdata;
        CFG_TOTAL_PAGES:  total_r  <= cfg_wdata[CNT_W-1:0];
        CFG_KERNEL_START: kstart_r <= cfg_wdata;
        CFG_KERNEL_END:   kend_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign frames = (total_r > MAX_CNT) ? MAX_CNT : total_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // free address check and frame number
  assign addr_ok = in_free_address >= base_r;
  assign ofs     = in_free_address - base_r;
  assign pfn     = ofs[ADDR_W-1:PAGE_SHIFT];
  assign pfn_ok  = pfn < PFN_W'(frames);
  assign rd_addr = (in_opcode == OP_FREE) ? pfn[FRAME_W-1:0] : head_r[FRAME_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    kern_nxt       = kern_r;
    idx_nxt        = idx_r;
    fail_nxt       = fail_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_zeroed_nxt = out_zeroed_r;
    out_count_nxt  = out_count_r;
    walk_cmd.go    = 1'b0;
    walk_cmd.clear = 1'b0;
    exec_wr.en          = 1'b0;
    exec_wr.addr        = idx_r;
    exec_wr.data.zeroed = 1'b0;
    exec_wr.data.kernel = 1'b0;
    exec_wr.data.in_use = 1'b0;
    exec_wr.data.link   = NULL_LINK;

    case (state_r)
      S_CLEAR: begin
        if (walk_stat.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_opcode;
          kern_nxt = in_for_kernel;
          idx_nxt  = rd_addr;
          if (in_opcode == OP_FREE) begin
            fail_nxt = !(addr_ok && pfn_ok);
          end else begin
            fail_nxt = head_r >= NULL_LINK;
          end
          if (in_opcode == OP_INIT) begin
            walk_cmd.go = 1'b1;
            head_nxt    = NULL_LINK;
            count_nxt   = '0;
            state_nxt   = S_INIT;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_INIT: begin
        if (walk_stat.push) begin
          head_nxt = {1'b0, walk_wr.addr};
        end
        if (walk_stat.reserve) begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (walk_stat.last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_page_nxt   = '0;
          out_zeroed_nxt = 1'b0;
          out_count_nxt  = count_nxt;
          state_nxt      = S_IDLE;
        end
      end
      S_EXEC: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_page_nxt   = '0;
        out_zeroed_nxt = 1'b0;
        state_nxt      = S_IDLE;
        if (op_r == OP_FREE) begin
          if (fail_r) begin
            out_status_nxt = STAT_BAD_ADDR;
          end else if (!rd_data.in_use) begin
            out_status_nxt = STAT_DOUBLE_FREE;
          end else begin
            exec_wr.en          = 1'b1;
            exec_wr.data.zeroed = 1'b1;
            exec_wr.data.link   = head_r;
            head_nxt            = {1'b0, idx_r};
            count_nxt           = count_r - CNT_W'(1);
          end
        end else begin
          // only one free list is kept, all of it marked zeroed, so both gets pop the zeroed list
          if (fail_r) begin
            out_status_nxt = (op_r == OP_GET) ? STAT_NO_PAGE : STAT_NO_ZERO;
          end else begin
            exec_wr.en          = 1'b1;
            exec_wr.data.zeroed = (op_r == OP_GET_ZERO);
            exec_wr.data.kernel = kern_r;
            exec_wr.data.in_use = 1'b1;
            head_nxt            = rd_data.link;
            count_nxt           = count_r + CNT_W'(1);
            out_page_nxt        = base_r + (ADDR_W'(idx_r) << PAGE_SHIFT);
            out_zeroed_nxt      = 1'b1;
          end
        end
        out_count_nxt = count_nxt;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= NULL_LINK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    kern_r       <= kern_nxt;
    idx_r        <= idx_nxt;
    fail_r       <= fail_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_zeroed_r <= out_zeroed_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign mem_wr = walk_stat.active ? walk_wr : exec_wr;

  pffa_init_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (walk_cmd),
    .base   (base_r),
    .kstart (kstart_r),
    .kend   (kend_r),
    .frames (frames),
    .head   (head_r),
    .wr     (walk_wr),
    .stat   (walk_stat)
  );

  pffa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_page_address    = out_page_r;
  assign out_page_was_zeroed = out_zeroed_r;
  assign out_frames_in_use   = out_count_r;

endmodule
`default_nettype wire

// File: src/pffa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/pffa_init_walk.sv
// frame table walker for the clearing pass and list rebuild
`default_nettype none
module pffa_init_walk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pffa_pkg::walk_cmd_t           cmd,
  input  wire logic [pffa_pkg::ADDR_W-1:0]   base,
  input  wire logic [pffa_pkg::ADDR_W-1:0]   kstart,
  input  wire logic [pffa_pkg::ADDR_W-1:0]   kend,
  input  wire logic [pffa_pkg::CNT_W-1:0]    frames,
  input  wire logic [pffa_pkg::LINK_W-1:0]   head,
  output      pffa_pkg::mem_wr_t             wr,
  output      pffa_pkg::walk_stat_t          stat
);
  import pffa_pkg::*;

  logic               active_r, active_nxt;
  logic               clear_r, clear_nxt;
  logic [FRAME_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic               in_range;
  logic               reserved;
  logic               last;

  // descending walk: pushing each free frame leaves the list ascending
  assign in_range = CNT_W'(idx_r) < frames;
  assign reserved = (idx_r == '0) || (start_r < kend && end_r > kstart) || (end_r <= kstart);
  assign last     = active_r && (idx_r == '0);

  always_comb begin
    active_nxt = active_r;
    clear_nxt  = clear_r;
    idx_nxt    = idx_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    if (cmd.go) begin
      active_nxt = 1'b1;
      clear_nxt  = cmd.clear;
      idx_nxt    = FRAME_W'(MAX_FRAMES - 1);
      start_nxt  = base + LAST_OFS;
      end_nxt    = base + END_OFS;
    end else if (active_r) begin
      idx_nxt   = idx_r - FRAME_W'(1);
      start_nxt = start_r - PAGE_BYTES;
      end_nxt   = end_r - PAGE_BYTES;
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      clear_r  <= 1'b1;
      idx_r    <= FRAME_W'(MAX_FRAMES - 1);
    end else begin
      active_r <= active_nxt;
      clear_r  <= clear_nxt;
      idx_r    <= idx_nxt;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  always_comb begin
    wr.en          = active_r;
    wr.addr        = idx_r;
    wr.data.zeroed = 1'b0;
    wr.data.kernel = 1'b0;
    wr.data.in_use = 1'b0;
    wr.data.link   = NULL_LINK;
    if (!clear_r && in_range) begin
      if (reserved) begin
        wr.data.kernel = 1'b1;
        wr.data.in_use = 1'b1;
      end else begin
        wr.data.zeroed = 1'b1;
        wr.data.link   = head;
      end
    end
  end

  assign stat.active  = active_r;
  assign stat.last    = last;
  assign stat.push    = active_r && !clear_r && in_range && !reserved;
  assign stat.reserve = active_r && !clear_r && in_range && reserved;

endmodule
`default_nettype wire

// File: src/pffa_checker.sv
// port level checks of the page frame allocator and their bind
`default_nettype none
module pffa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [pffa_pkg::STAT_W-1:0]   out_status,
  input wire logic [pffa_pkg::ADDR_W-1:0]   out_page_address,
  input wire logic [pffa_pkg::CNT_W-1:0]    out_frames_in_use
);
  import pffa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STAT_BAD_ADDR)
    else $error("unknown status code");

  a_fail_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_page_address == '0)
    else $error("failed request returned a page");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames_in_use <= MAX_CNT)
    else $error("frame count above table size");

endmodule

bind page_frame_free_list_allocator_core pffa_checker u_pffa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_page_address  (out_page_address),
  .out_frames_in_use (out_frames_in_use)
);
`default_nettype wire
